/* sv/hrb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hrb_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int ENTRY_BYTES_DEF = 8;

    localparam int DATA_W   = 64;
    localparam int OFFSET_W = 8;
    localparam int SEQ_W    = 32;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                 op;
        logic [DATA_W-1:0]   wr_data;
        logic [OFFSET_W-1:0] back_offset;
    } req_t;

    typedef struct packed
    {
        logic [SEQ_W-1:0]  seq_number;
        logic [DATA_W-1:0] rd_data;
        logic              bad_offset;
        logic              is_full;
        logic              is_empty;
    } rsp_t;

endpackage : hrb_pkg

`default_nettype wire

/* sv/history_ring_buffer.sv */
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall  req_t: op, wr_data, back_offset
// rsp      out        rsp_valid/rsp_stall  rsp_t: seq_number, rd_data, bad_offset,
//                                          is_full, is_empty
//
// One request per cycle while req_stall is low; the single RAM port takes one access each cycle.
// A request passes through the RAM access, then the response register.
// Reset clears the write count and the full flag; the RAM is not cleared.
// A stalled response holds one request in the middle stage; a further
// request is stalled until the response register frees.
`timescale 1ns / 1ps
`default_nettype none

module history_ring_buffer
    import hrb_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int ENTRY_BYTES = ENTRY_BYTES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int               AW      = $clog2(DEPTH);
    localparam int               EW      = 8 * ENTRY_BYTES;
    localparam logic [SEQ_W-1:0] DEPTH_W = SEQ_W'(DEPTH);

    typedef struct packed
    {
        logic             is_read;
        logic             bad;
        logic [SEQ_W-1:0] seq;
        logic             full;
        logic             empty;
    } pend_t;

    logic [SEQ_W-1:0] wc_reg, wc_next;
    logic             wrapped_reg, wrapped_next;
    logic             pend_valid_reg, pend_valid_next;
    pend_t            pend_reg, pend_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             req_fire;
    logic             out_free;
    logic             is_wr;
    logic [SEQ_W-1:0] wc_inc;
    logic [SEQ_W-1:0] off_w;
    logic [SEQ_W-1:0] rd_ptr;
    logic             rd_bad;
    logic             ram_en;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [EW-1:0]    ram_rdata;

    always_comb
    begin
        out_free  = !rsp_valid_reg || !rsp_stall;
        req_stall = pend_valid_reg && !out_free;
        req_fire  = req_valid && !req_stall;
        is_wr     = (req.op == OP_WRITE);
        wc_inc    = wc_reg + SEQ_W'(1);
        off_w     = SEQ_W'(req.back_offset);
        rd_ptr    = wc_reg - off_w;
        // zero offset only legal once the ring has wrapped (oldest entry)
        rd_bad    = (off_w >= DEPTH_W)
                 || (!wrapped_reg && ((req.back_offset == '0) || (off_w > wc_reg)));

        ram_en   = req_fire;
        ram_we   = req_fire && is_wr;
        ram_addr = is_wr ? wc_reg[AW-1:0] : rd_ptr[AW-1:0];

        wc_next      = (req_fire && is_wr) ? wc_inc : wc_reg;
        wrapped_next = wrapped_reg || (req_fire && is_wr && (wc_inc >= DEPTH_W));

        pend_next         = pend_reg;
        pend_valid_next   = out_free ? 1'b0 : pend_valid_reg;
        if (req_fire)
        begin
            pend_valid_next   = 1'b1;
            pend_next.is_read = !is_wr;
            pend_next.bad     = !is_wr && rd_bad;
            pend_next.seq     = is_wr ? wc_reg : '0;
            pend_next.full    = wrapped_next;
            pend_next.empty   = !is_wr && (wc_reg == '0) && !wrapped_reg;
        end

        rsp_valid_next = out_free ? pend_valid_reg : rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (pend_valid_reg && out_free)
        begin
            rsp_next.seq_number = pend_reg.seq;
            rsp_next.rd_data    = (pend_reg.is_read && !pend_reg.bad)
                                ? DATA_W'(ram_rdata) : '0;
            rsp_next.bad_offset = pend_reg.bad;
            rsp_next.is_full    = pend_reg.full;
            rsp_next.is_empty   = pend_reg.empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg         <= '0;
            wrapped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            wc_reg         <= wc_next;
            wrapped_reg    <= wrapped_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    hrb_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (req.wr_data[EW-1:0]),
        .rdata (ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_bad_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.bad_offset |-> rsp_reg.rd_data == '0)
        else $error("rejected read carries data");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.is_full && rsp_reg.is_empty))
        else $error("full and empty together");

    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("full flag dropped");

    a_count_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_fire && is_wr) |=> $stable(wc_reg))
        else $error("write count moved without a write");

    a_fire_fills_pend: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> pend_valid_reg)
        else $error("accepted request lost");

endmodule : history_ring_buffer

`default_nettype wire

/* sv/hrb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read data holds until the next enabled read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule : hrb_ram

`default_nettype wire
